/* sv/sha256_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [15:0][31:0] t_block;
    typedef logic [7:0][31:0]  t_chain;

    // commands from the byte sequencer to the compression unit
    typedef struct packed {
        logic start;
        logic init;
    } t_core_ctrl;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LENGTH_POS = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    localparam t_word H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word K_ROUND [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

`default_nettype wire

/* sv/sha256_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, msg_byte, has_byte, end_of_message, input ready);
    modport sink   (input valid, msg_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

/* sv/sha256_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module sha256_core
    import sha256_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_core_ctrl i_ctrl,
    input  wire t_block     i_block,
    output logic            o_done,
    output t_chain          o_chain
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_ADD
    } t_state;

    t_state     r_state;
    logic [5:0] r_round;
    t_block     r_w;
    t_chain     r_s;
    t_chain     r_chain;
    logic       r_done;

    t_chain     n_s;
    t_word      n_w;
    t_word      w_t1;
    t_word      w_t2;

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    // one round: s[0] is a ... s[7] is h, r_w[0] is the current schedule word
    always_comb begin
        w_t1 = r_s[7] + big_sigma1(r_s[4]) + ((r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]))
             + K_ROUND[r_round] + r_w[0];
        w_t2 = big_sigma0(r_s[0])
             + ((r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]));
        n_s  = {r_s[6], r_s[5], r_s[4], r_s[3] + w_t1, r_s[2], r_s[1], r_s[0], w_t1 + w_t2};
        n_w  = r_w[0] + small_sigma0(r_w[1]) + r_w[9] + small_sigma1(r_w[14]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= H_INIT[i];
            end
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_ctrl.init) begin
                        for (int i = 0; i < 8; i++) begin
                            r_chain[i] <= H_INIT[i];
                        end
                    end
                    if (i_ctrl.start) begin
                        r_w     <= i_block;
                        r_s     <= r_chain;
                        r_round <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_s     <= n_s;
                    // schedule window slides by one word
                    r_w     <= {n_w, r_w[15:1]};
                    r_round <= r_round + 6'd1;
                    if (r_round == LAST_POS) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_s[i];
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_chain = r_chain;

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> r_state == S_IDLE)
        else $error("compression start while busy");

    a_add_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round == LAST_POS) |=> (r_state == S_ADD))
        else $error("final add does not follow round 63");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held longer than one cycle");

    a_no_init_with_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.start && i_ctrl.init))
        else $error("chain init together with start");

endmodule

`default_nettype wire

/* sv/sha256_message_digest_top.sv */
// a byte request is taken only while idle; a byte that fills a 64-byte block starts a
// compression (load, 64 rounds on the shared round unit, chain add, done handoff),
// during which no further bytes are accepted
// an end-of-message request adds one padding byte per cycle plus one or two compressions,
// then the eight digest words leave one per cycle as the sink takes them
// reset (synchronous, active low) loads the initial hash values and empties the byte buffer
`timescale 1ns / 1ps
`default_nettype none

module sha256_message_digest_top
    import sha256_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    sha256_in_if.sink     i_msg,
    sha256_out_if.source  o_dig
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMP,
        S_PAD,
        S_OUT
    } t_state;

    t_state      r_state;
    logic [5:0]  r_pos;
    logic [63:0] r_count;
    logic [63:0] r_len_val;
    logic        r_ending;
    logic        r_mark;
    logic        r_len;
    logic [2:0]  r_out_idx;
    t_core_ctrl  r_ctrl;
    t_block      r_block;

    logic        w_in_fire;
    logic        w_out_fire;
    logic        w_len_now;
    logic        w_push;
    logic [7:0]  w_push_byte;
    logic [63:0] w_len_shift;
    logic        w_done;
    t_chain      w_chain;

    assign i_msg.ready = (r_state == S_IDLE);
    assign w_in_fire   = i_msg.valid && i_msg.ready;
    assign w_out_fire  = o_dig.valid && o_dig.ready;

    // length bytes start once the mark is in and the position reaches 56
    assign w_len_now   = r_mark && (r_len || (r_pos == LENGTH_POS));
    assign w_len_shift = r_len_val >> {~r_pos[2:0], 3'b000};

    always_comb begin
        w_push      = 1'b0;
        w_push_byte = '0;
        case (r_state)
            S_IDLE: begin
                w_push      = w_in_fire && i_msg.has_byte;
                w_push_byte = i_msg.msg_byte;
            end
            S_PAD: begin
                w_push = 1'b1;
                if (!r_mark) begin
                    w_push_byte = PAD_MARK;
                end else if (w_len_now) begin
                    w_push_byte = w_len_shift[7:0];
                end else begin
                    w_push_byte = '0;
                end
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_block[r_pos[5:2]][{~r_pos[1:0], 3'b000} +: 8] <= w_push_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_count   <= '0;
            r_ending  <= 1'b0;
            r_mark    <= 1'b0;
            r_len     <= 1'b0;
            r_out_idx <= '0;
            r_ctrl    <= '0;
        end else begin
            r_ctrl <= '0;
            if (w_push) begin
                r_pos <= r_pos + 6'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        if (i_msg.has_byte) begin
                            r_count <= r_count + 64'd8;
                        end
                        if (i_msg.end_of_message) begin
                            r_ending  <= 1'b1;
                            r_len_val <= i_msg.has_byte ? r_count + 64'd8 : r_count;
                        end
                        if (i_msg.has_byte && r_pos == LAST_POS) begin
                            r_ctrl.start <= 1'b1;
                            r_state      <= S_COMP;
                        end else if (i_msg.end_of_message) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_mark <= 1'b1;
                    r_len  <= w_len_now;
                    if (r_pos == LAST_POS) begin
                        r_ctrl.start <= 1'b1;
                        r_state      <= S_COMP;
                    end
                end
                S_COMP: begin
                    if (w_done) begin
                        if (!r_ending) begin
                            r_state <= S_IDLE;
                        end else if (r_len) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_fire) begin
                        r_out_idx <= r_out_idx + 3'd1;
                        if (r_out_idx == LAST_WORD) begin
                            r_ctrl.init <= 1'b1;
                            r_count     <= '0;
                            r_ending    <= 1'b0;
                            r_mark      <= 1'b0;
                            r_len       <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    sha256_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_ctrl),
        .i_block (r_block),
        .o_done  (w_done),
        .o_chain (w_chain)
    );

    assign o_dig.valid       = (r_state == S_OUT);
    assign o_dig.digest_word = w_chain[r_out_idx];
    assign o_dig.word_index  = r_out_idx;
    assign o_dig.last_word   = (r_out_idx == LAST_WORD);

    a_start_on_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.start |-> r_pos == '0)
        else $error("compression started on a partial block");

    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_state == S_COMP)
        else $error("compression finished outside the wait state");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_msg.ready && o_dig.valid))
        else $error("input taken while digest words are pending");

endmodule

`default_nettype wire
